### hw/rtl/sks_pkg.sv
// sks_pkg: shared types and constants for the sorted key set table.
// Holds operation and status codes, the cell link and command structs.
// No dependencies.
`default_nettype none

package sks_pkg;

  localparam int KEY_W = 32;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;

  // operation codes carried in the input word
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             valid;
    logic             lt;     // holds a key below the probe key
  } sks_link_t;

  // broadcast command to every cell
  typedef struct packed {
    logic             ins;
    logic             del;
    logic             clr;
    logic [KEY_W-1:0] key;
  } sks_cmd_t;

  // per-cell flags back to the top level
  typedef struct packed {
    logic eq;    // holds the probe key
    logic bnd;   // first cell not below the probe key
  } sks_flag_t;

endpackage

`default_nettype wire

### hw/rtl/sorted_key_set_table.sv
// sorted_key_set_table: bounded ascending set of signed keys in a cell chain.
// Instantiates sks_cell (one per slot) and sks_pos_enc; uses sks_pkg.
//
//   channel   direction  ports
//   in        sink       in_valid, in_stall, in_operation, in_key
//   out       source     out_valid, out_stall, out_status, out_position,
//                        out_entry_count
//
// One word per cycle while in_stall is low: all cells compare and shift in the
// same cycle the word is taken, and the result is loaded into the output
// register at that same edge, so out_valid rises in the next cycle.
// in_stall is high only while a result waits and out_stall holds it.
// rst_n is synchronous: clears the count, all slot valid bits and out_valid.
// Slot keys are not reset; only valid slots are ever compared.
`default_nettype none

module sorted_key_set_table
  import sks_pkg::*;
#(
  parameter int CAPACITY = 16,
  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [OP_W-1:0]         in_operation,
  input  wire logic signed [KEY_W-1:0] in_key,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [ST_W-1:0]              out_status,
  output logic [PW-1:0]                out_position,
  output logic [CW-1:0]                out_entry_count
);

  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  sks_link_t             links  [CAPACITY];
  sks_flag_t             flags  [CAPACITY];
  logic [CAPACITY-1:0]   eq_vec, bnd_vec, valid_vec;
  sks_link_t             head_link, tail_link;
  sks_cmd_t              cmd;

  logic                  in_acc;
  op_t                   op;
  logic                  hit, full;
  logic [PW-1:0]         bnd_pos;

  logic [CW-1:0]         count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]       status_r, status_nxt;
  logic [PW-1:0]         pos_r, pos_nxt;
  logic [CW-1:0]         cnt_out_r;

  // handshake: one output register
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign op        = op_t'(in_operation);

  // chain ends: everything sits above the head, nothing beyond the tail
  assign head_link = '{key: '0, valid: 1'b0, lt: 1'b1};
  assign tail_link = '{key: '0, valid: 1'b0, lt: 1'b0};

  // cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    sks_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .prev_link ((g == 0) ? head_link : links[(g == 0) ? 0 : g - 1]),
      .next_link ((g == CAPACITY - 1) ? tail_link
                  : links[(g == CAPACITY - 1) ? g : g + 1]),
      .link      (links[g]),
      .flag      (flags[g])
    );
    assign eq_vec[g]    = flags[g].eq;
    assign bnd_vec[g]   = flags[g].bnd;
    assign valid_vec[g] = links[g].valid;
  end

  sks_pos_enc #(
    .N (CAPACITY),
    .W (PW)
  ) u_pos_enc (
    .onehot (bnd_vec),
    .index  (bnd_pos)
  );

  assign hit  = |eq_vec;
  assign full = (count_r == CAP_CNT);

  // decode the word into a chain command and a result
  always_comb begin
    cmd           = '{ins: 1'b0, del: 1'b0, clr: 1'b0, key: in_key};
    count_nxt     = count_r;
    status_nxt    = ST_OK;
    pos_nxt       = '0;
    out_valid_nxt = out_valid_r && out_stall;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      unique case (op)
        OP_INSERT: begin
          priority if (hit) begin
            status_nxt = ST_MISS;
            pos_nxt    = bnd_pos;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd.ins   = 1'b1;
            pos_nxt   = bnd_pos;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_DELETE: begin
          if (hit) begin
            cmd.del   = 1'b1;
            pos_nxt   = bnd_pos;
            count_nxt = count_r - 1'b1;
          end else begin
            status_nxt = ST_MISS;
          end
        end
        OP_SEARCH: begin
          if (hit) begin
            pos_nxt = bnd_pos;
          end else begin
            status_nxt = ST_MISS;
          end
        end
        OP_CLEAR: begin
          cmd.clr   = 1'b1;
          count_nxt = '0;
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded on accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r  <= status_nxt;
      pos_r     <= pos_nxt;
      cnt_out_r <= count_nxt;
    end
  end

  assign out_status      = status_r;
  assign out_position    = pos_r;
  assign out_entry_count = cnt_out_r;

  // count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count above capacity");

  // occupied slots match the count
  a_count_slots: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("slot valid bits disagree with count");

  // a clear empties the table
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (op == OP_CLEAR) |=> (count_r == '0) && (valid_vec == '0))
    else $error("clear left entries");

  // table-full status only comes from a full table
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status == ST_FULL) |-> full && (out_entry_count == CAP_CNT))
    else $error("full status without full table");

  // slots stay packed from the bottom
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec + 1'b1) & valid_vec) == '0)
    else $error("slot valid bits not contiguous");

endmodule

`default_nettype wire

### hw/rtl/sks_cell.sv
// sks_cell: one slot of the sorted chain, holding a key and its valid bit.
// Compares against the broadcast key and shifts from a neighbor on update.
// Depends on sks_pkg.
`default_nettype none

module sks_cell
  import sks_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire sks_cmd_t  cmd,
  input  wire sks_link_t prev_link,
  input  wire sks_link_t next_link,
  output sks_link_t      link,
  output sks_flag_t      flag
);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic             valid_r, valid_nxt;
  logic             lt;

  // compare against the probe key
  assign lt       = valid_r && ($signed(key_r) < $signed(cmd.key));
  assign flag.eq  = valid_r && (key_r == cmd.key);
  assign flag.bnd = !lt && prev_link.lt;

  assign link.key   = key_r;
  assign link.valid = valid_r;
  assign link.lt    = lt;

  // insert shifts up from below, delete shifts down from above
  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    priority if (cmd.clr) begin
      valid_nxt = 1'b0;
    end else if (cmd.ins && !lt) begin
      if (prev_link.lt) begin
        key_nxt   = cmd.key;
        valid_nxt = 1'b1;
      end else begin
        key_nxt   = prev_link.key;
        valid_nxt = prev_link.valid;
      end
    end else if (cmd.del && !lt) begin
      key_nxt   = next_link.key;
      valid_nxt = next_link.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // key payload, no reset
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

`default_nettype wire

### hw/rtl/sks_pos_enc.sv
// sks_pos_enc: one-hot to binary encoder for the chain boundary flag.
// OR tree per output bit; returns zero when no bit is set.
// Depends on sks_pkg.
`default_nettype none

module sks_pos_enc
  import sks_pkg::*;
#(
  parameter int N = 16,
  parameter int W = 4
) (
  input  wire logic [N-1:0] onehot,
  output logic      [W-1:0] index
);

  always_comb begin
    index = '0;
    for (int i = 0; i < N; i++) begin
      index = index | ({W{onehot[i]}} & W'(i));
    end
  end

endmodule

`default_nettype wire

### sim/sorted_key_set_table_test.sv
// sorted_key_set_table_test: self-checking bench for the sorted key set table.
// Drives insert/delete/search/clear words, predicts every result in a scoreboard.
// Depends on sks_pkg and sorted_key_set_table only.
`default_nettype none

module sorted_key_set_table_test;
  import sks_pkg::*;

  localparam int CAP       = 16;
  localparam int POOL_N    = 24;
  localparam int RAND_N    = 1500;
  localparam int IDLE_PCT  = 23;
  localparam int HANG_MAX  = 2000;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  // expected content of one result word
  typedef struct {
    status_t    status;
    logic [3:0] position;
    logic [4:0] count;
  } table_result_t;

  // mirrors the table contents and queues the result each word should give
  class key_table_scoreboard;
    logic signed [KEY_W-1:0] held[CAP];
    int unsigned             held_n;
    table_result_t           awaited[$];
    int                      errors;

    function new();
      held_n = 0;
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    function int pending();
      return awaited.size();
    endfunction

    // apply one accepted word to the mirror and queue its result
    function void note_word(op_t op, logic signed [KEY_W-1:0] key);
      int unsigned   slot;
      bit            hit;
      table_result_t r;
      slot = 0;
      while (slot < held_n && held[slot] < key) slot++;
      hit = (slot < held_n) && (held[slot] == key);
      r.status   = ST_OK;
      r.position = '0;
      case (op)
        OP_INSERT: begin
          if (hit) begin
            r.status   = ST_MISS;
            r.position = slot[3:0];
          end else if (held_n >= CAP) begin
            r.status = ST_FULL;
          end else begin
            for (int j = held_n; j > slot; j--) held[j] = held[j-1];
            held[slot] = key;
            held_n++;
            r.position = slot[3:0];
          end
        end
        OP_DELETE: begin
          if (hit) begin
            for (int j = slot; j + 1 < held_n; j++) held[j] = held[j+1];
            held_n--;
            r.position = slot[3:0];
          end else begin
            r.status = ST_MISS;
          end
        end
        OP_SEARCH: begin
          if (hit) r.position = slot[3:0];
          else r.status = ST_MISS;
        end
        default: held_n = 0;
      endcase
      r.count = held_n[4:0];
      awaited.push_back(r);
    endfunction

    // compare one result word against the oldest expectation
    task check_word(logic [ST_W-1:0] st, logic [3:0] pos, logic [4:0] cnt);
      table_result_t r;
      if (awaited.size() == 0) begin
        report($sformatf("result st=%0d pos=%0d cnt=%0d with nothing pending",
                         st, pos, cnt));
      end else begin
        r = awaited.pop_front();
        if (st !== r.status)
          report($sformatf("status %0d, expected %0d", st, r.status));
        if (pos !== r.position)
          report($sformatf("position %0d, expected %0d", pos, r.position));
        if (cnt !== r.count)
          report($sformatf("entry_count %0d, expected %0d", cnt, r.count));
      end
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [OP_W-1:0]         in_operation;
  logic signed [KEY_W-1:0] in_key;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [ST_W-1:0]         out_status;
  logic [3:0]              out_position;
  logic [4:0]              out_entry_count;

  key_table_scoreboard     sb;
  bit                      quiet;
  int                      hang_cycles = 0;
  logic signed [KEY_W-1:0] key_pool[POOL_N];

  sorted_key_set_table #(.CAPACITY(CAP)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_entry_count (out_entry_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side backpressure
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_word(out_status, out_position, out_entry_count);
  end

  // hang watchdog: cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      hang_cycles <= 0;
    end else begin
      hang_cycles <= hang_cycles + 1;
      if (hang_cycles >= HANG_MAX) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // present one word, hold it until taken; enters and leaves on a falling edge
  task send_word(op_t op, logic signed [KEY_W-1:0] key);
    while (!quiet && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key       <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(op, key);
    @(negedge clk);
  endtask

  // stop sending until every queued result is back
  task wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // keys mostly from a small pool so hits, duplicates and full tables happen
  task refill_pool();
    for (int i = 0; i < POOL_N; i++) begin
      if ($urandom_range(0, 1)) key_pool[i] = $urandom;
      else key_pool[i] = $signed($urandom_range(0, 60)) - 30;
    end
  endtask

  function logic signed [KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return $urandom;
    if (roll < 23) begin
      case ($urandom_range(0, 3))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return key_pool[$urandom_range(0, POOL_N - 1)];
  endfunction

  function op_t pick_op();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 42) return OP_INSERT;
    if (roll < 64) return OP_DELETE;
    if (roll < 97) return OP_SEARCH;
    return OP_CLEAR;
  endfunction

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_INSERT;
    in_key       = '0;
    quiet        = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, extremes, duplicate, misses, full table, clear
    send_word(OP_SEARCH, 32'sd7);
    send_word(OP_DELETE, 32'sd7);
    send_word(OP_INSERT, 32'sd0);
    send_word(OP_INSERT, KEY_MIN);
    send_word(OP_INSERT, KEY_MAX);
    send_word(OP_INSERT, -32'sd1);
    send_word(OP_INSERT, 32'sd0);
    send_word(OP_SEARCH, KEY_MIN);
    send_word(OP_DELETE, KEY_MAX);
    send_word(OP_DELETE, 32'sd5);
    for (int i = 1; i <= 13; i++) send_word(OP_INSERT, i * 1000);
    send_word(OP_INSERT, 32'sd5);
    send_word(OP_INSERT, 32'sd13000);
    send_word(OP_SEARCH, 32'sd13000);
    send_word(OP_CLEAR, $urandom);
    wait_drained();

    // random traffic with a quiet stretch and a couple of drains
    for (int n = 0; n < RAND_N; n++) begin
      if (n % 250 == 0) refill_pool();
      quiet = (n >= 600) && (n < 900);
      if (n == 500 || n == 1100) wait_drained();
      send_word(pick_op(), pick_key());
    end
    quiet = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
